[hdl/mchm_pkg.sv]
// Shared types, codes and constants for the multi-channel heartbeat monitor.
package mchm_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam logic [15:0] STABLE_RESET = 16'd100;
    localparam logic [15:0] TO_NEVER = 16'hFFFF;
    localparam logic [15:0] TO_OFF = 16'h0000;
    localparam int DIV_STEPS = 16;

    // operation codes carried by an input item
    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_FEED  = 3'd1,
        OP_REG   = 3'd2,
        OP_UNREG = 3'd3,
        OP_QUERY = 3'd4
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DUP    = 2'd1,
        ST_NOSLOT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_SLOT,
        S_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic div_step;
        logic slot_step;
        logic resp_do;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       upd;
        logic       div_done;
        logic       out_free;
        logic       idx_last;
    } t_stat;

endpackage

[hdl/multi_channel_heartbeat_monitor.sv]
// Top level of the multi-channel heartbeat monitor: controller, datapath, checks.
//
// Tracks up to CHANNELS heartbeat slots. Register, unregister, feed and query
// items each give one result, after the decode and response states, and the
// next item is taken once the controller is back in idle. A tick item gives
// one result per slot, the last one marked. While any slot is registered, a
// tick first runs a 16-step serial divider (stable_time_ms over the tick
// interval), then walks the slots one per cycle while the output is not
// stalled. One item is worked on at a time; the result register lets the last
// result of an item wait while the next item is accepted. The configuration
// port is always ready and must only be written while the block is idle.
module multi_channel_heartbeat_monitor #(
    parameter int CHANNELS = mchm_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [2:0]  i_channel,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_init_wait_ms,
    input  logic [15:0] i_reload_timeout_ms,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_slot,
    output logic        o_in_use,
    output logic        o_online,
    output logic        o_changed,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slots_used,
    output logic        o_last
);
    import mchm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    mchm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mchm_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_opcode            (i_opcode),
        .i_channel           (i_channel),
        .i_now_ms            (i_now_ms),
        .i_init_wait_ms      (i_init_wait_ms),
        .i_reload_timeout_ms (i_reload_timeout_ms),
        .i_cfg_valid         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_slot              (o_slot),
        .o_in_use            (o_in_use),
        .o_online            (o_online),
        .o_changed           (o_changed),
        .o_status            (o_status),
        .o_slots_used        (o_slots_used),
        .o_last              (o_last)
    );

    // an accepted item keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after an accepted item");

    // every result load shows up on the output
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.slot_step || cmd.resp_do) |=> o_out_valid)
        else $error("result load lost");

    // slot walk and response never load in the same cycle
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.slot_step && cmd.resp_do))
        else $error("two result loads at once");

endmodule

[hdl/mchm_ctrl.sv]
// Controller state machine: sequences decode, divide, slot walk and response.
module mchm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mchm_pkg::t_stat i_stat,
    output mchm_pkg::t_cmd  o_cmd
);
    import mchm_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op == OP_TICK) begin
                    n_state = i_stat.upd ? S_DIV : S_SLOT;
                end else if (i_stat.op inside {OP_FEED, OP_REG, OP_UNREG, OP_QUERY}) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_SLOT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_SLOT: begin
                if (i_stat.out_free) begin
                    o_cmd.slot_step = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.resp_do = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/mchm_datapath.sv]
// Datapath: slot state, tick interval divider, slot update logic and result register.
module mchm_datapath #(
    parameter int CHANNELS = mchm_pkg::CHANNELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mchm_pkg::t_cmd  i_cmd,
    output mchm_pkg::t_stat o_stat,
    input  logic [2:0]      i_opcode,
    input  logic [2:0]      i_channel,
    input  logic [31:0]     i_now_ms,
    input  logic [15:0]     i_init_wait_ms,
    input  logic [15:0]     i_reload_timeout_ms,
    input  logic            i_cfg_valid,
    input  logic [15:0]     i_cfg_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [2:0]      o_slot,
    output logic            o_in_use,
    output logic            o_online,
    output logic            o_changed,
    output logic [1:0]      o_status,
    output logic [3:0]      o_slots_used,
    output logic            o_last
);
    import mchm_pkg::*;

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int UW = $clog2(CHANNELS + 1);

    // control state
    logic [CHANNELS-1:0] r_valid;
    logic [31:0]         r_prev;
    logic [UW-1:0]       r_used;
    logic [15:0]         r_stable;
    logic                r_out_valid;
    logic [4:0]          r_cnt;
    logic [IW-1:0]       r_idx;

    // latched item and divider
    logic [2:0]  r_op;
    logic [2:0]  r_ch;
    logic [31:0] r_now;
    logic [15:0] r_iw;
    logic [15:0] r_to;
    logic [31:0] r_diff;
    logic        r_upd;
    logic [16:0] r_rem;
    logic [15:0] r_quo;

    // per-slot stores
    logic [15:0] r_init [CHANNELS];
    logic [15:0] r_tmo [CHANNELS];
    logic [31:0] r_wait [CHANNELS];
    logic [15:0] r_sc [CHANNELS];
    logic [31:0] r_stamp [CHANNELS];
    logic        r_on [CHANNELS];
    logic        r_oprev [CHANNELS];

    // result register payload
    logic [2:0] r_o_slot;
    logic       r_o_in_use, r_o_online, r_o_changed, r_o_last;
    logic [1:0] r_o_status;
    logic [3:0] r_o_used;

    // interval since the previous tick, at least one
    logic [31:0] n_diff;
    assign n_diff = (i_now_ms - r_prev == 32'd0) ? 32'd1 : i_now_ms - r_prev;

    // one restoring divider step
    logic [16:0] n_trial;
    logic        n_ge;
    assign n_trial = {r_rem[15:0], r_quo[15]};
    assign n_ge    = {15'd0, n_trial} >= r_diff;

    // addressed channel
    logic [IW+2:0] ch_ext;
    logic [IW-1:0] chi;
    logic          ch_in, ok;
    assign ch_ext = (IW+3)'(r_ch);
    assign chi    = ch_ext[IW-1:0];
    assign ch_in  = 32'(r_ch) < CHANNELS;
    assign ok     = ch_in && r_valid[chi];

    // tick update of the walked slot
    logic [15:0] cur_iw, cur_to, cur_sc;
    logic [31:0] cur_wait, cur_stamp, w_wsum, w_age;
    logic        cur_valid, cur_on;
    logic [15:0] w_thr, w_c;
    logic [31:0] n_wait;
    logic [15:0] n_sc;
    logic        n_on, n_act;

    assign cur_iw    = r_init[r_idx];
    assign cur_to    = r_tmo[r_idx];
    assign cur_sc    = r_sc[r_idx];
    assign cur_wait  = r_wait[r_idx];
    assign cur_stamp = r_stamp[r_idx];
    assign cur_valid = r_valid[r_idx];
    assign cur_on    = r_on[r_idx];
    assign w_wsum    = cur_wait + r_diff;
    assign w_age     = r_now - cur_stamp;
    assign w_thr     = (r_quo == 16'd0) ? 16'd1 : r_quo;
    assign w_c       = cur_sc + 16'd1;
    assign n_act     = r_upd && cur_valid;

    always_comb begin
        n_wait = cur_wait;
        n_sc   = cur_sc;
        n_on   = cur_on;
        if (n_act) begin
            if (cur_wait <= {16'd0, cur_iw}) begin
                n_wait = w_wsum;
                if (w_wsum > {16'd0, cur_iw}) begin
                    n_on = 1'b1;
                end
            end else if (w_age > {16'd0, cur_to}) begin
                n_on = (cur_to == TO_NEVER) || (cur_to == TO_OFF);
                n_sc = 16'd0;
            end else if (w_c >= w_thr) begin
                n_sc = 16'd0;
                n_on = 1'b1;
            end else begin
                n_sc = w_c;
            end
        end
    end

    // slot count after a response
    logic [UW-1:0]  n_used;
    logic [UW+3:0]  used_ext;
    logic [IW+2:0]  idx_ext;
    logic           do_reg, do_unreg;
    assign do_reg   = (r_op == OP_REG) && ch_in && !r_valid[chi];
    assign do_unreg = (r_op == OP_UNREG) && ok;
    always_comb begin
        n_used = r_used;
        if (do_reg) begin
            n_used = r_used + UW'(1);
        end else if (do_unreg) begin
            n_used = r_used - UW'(1);
        end
    end
    assign used_ext = (UW+4)'(n_used);
    assign idx_ext  = (IW+3)'(r_idx);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_prev      <= 32'd0;
            r_used      <= '0;
            r_stable    <= STABLE_RESET;
            r_out_valid <= 1'b0;
            r_cnt       <= 5'd0;
            r_idx       <= '0;
            r_upd       <= 1'b0;
            r_op        <= 3'd0;
        end else begin
            if (i_cfg_valid) begin
                r_stable <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.latch) begin
                r_op  <= i_opcode;
                r_upd <= r_used != '0;
                r_cnt <= 5'd0;
                r_idx <= '0;
                if (i_opcode == OP_TICK && r_used != '0) begin
                    r_prev <= i_now_ms;
                end
            end
            if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (i_cmd.slot_step) begin
                r_out_valid <= 1'b1;
                r_idx       <= r_idx + IW'(1);
            end
            if (i_cmd.resp_do) begin
                r_out_valid <= 1'b1;
                r_used      <= n_used;
                if (do_reg) begin
                    r_valid[chi] <= 1'b1;
                end
                if (do_unreg) begin
                    r_valid[chi] <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_ch   <= i_channel;
            r_now  <= i_now_ms;
            r_iw   <= i_init_wait_ms;
            r_to   <= i_reload_timeout_ms;
            r_diff <= n_diff;
            r_rem  <= 17'd0;
            r_quo  <= r_stable;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_ge ? n_trial - r_diff[16:0] : n_trial;
            r_quo <= {r_quo[14:0], n_ge};
        end
        if (i_cmd.slot_step) begin
            if (n_act) begin
                r_wait[r_idx] <= n_wait;
                r_sc[r_idx]   <= n_sc;
                r_on[r_idx]   <= n_on;
            end
            if (cur_valid) begin
                r_oprev[r_idx] <= n_on;
            end
            r_o_slot    <= idx_ext[2:0];
            r_o_in_use  <= cur_valid;
            r_o_online  <= cur_valid && n_on;
            r_o_changed <= cur_valid && (n_on != r_oprev[r_idx]);
            r_o_status  <= ST_OK;
            r_o_used    <= used_ext[3:0];
            r_o_last    <= r_idx == IW'(CHANNELS - 1);
        end
        if (i_cmd.resp_do) begin
            r_o_slot    <= r_ch;
            r_o_changed <= 1'b0;
            r_o_last    <= 1'b1;
            r_o_used    <= used_ext[3:0];
            if (do_reg) begin
                r_init[chi]  <= r_iw;
                r_tmo[chi]   <= r_to;
                r_wait[chi]  <= 32'd0;
                r_sc[chi]    <= 16'd0;
                r_stamp[chi] <= r_now;
                r_on[chi]    <= 1'b1;
                r_oprev[chi] <= 1'b1;
                r_o_in_use   <= 1'b1;
                r_o_online   <= 1'b1;
                r_o_status   <= ST_OK;
            end else if (do_unreg) begin
                r_o_in_use <= 1'b0;
                r_o_online <= 1'b0;
                r_o_status <= ST_OK;
            end else if (ok) begin
                if (r_op == OP_FEED) begin
                    r_stamp[chi] <= r_now;
                end
                r_o_in_use <= 1'b1;
                r_o_online <= r_on[chi];
                r_o_status <= (r_op == OP_REG) ? ST_DUP : ST_OK;
            end else begin
                r_o_in_use <= 1'b0;
                r_o_online <= 1'b0;
                r_o_status <= ST_NOSLOT;
            end
        end
    end

    // status to the controller
    assign o_stat.op       = r_op;
    assign o_stat.upd      = r_upd;
    assign o_stat.div_done = r_cnt == 5'(DIV_STEPS);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_stat.idx_last = r_idx == IW'(CHANNELS - 1);

    assign o_out_valid  = r_out_valid;
    assign o_slot       = r_o_slot;
    assign o_in_use     = r_o_in_use;
    assign o_online     = r_o_online;
    assign o_changed    = r_o_changed;
    assign o_status     = r_o_status;
    assign o_slots_used = r_o_used;
    assign o_last       = r_o_last;

endmodule
